// File: sv/lrd_pkg.sv
// Shared types and constants for the lens response deframer.
// No dependencies; used by lens_response_deframer_unit.
`default_nettype none
package lrd_pkg;

    localparam int BYTE_POS_W = 17;

    typedef logic [BYTE_POS_W-1:0] t_byte_pos;

    // Frame layout: sync, id, length low, length high, payload, checksum
    localparam t_byte_pos POS_SYNC    = t_byte_pos'(0);
    localparam t_byte_pos POS_ID      = t_byte_pos'(1);
    localparam t_byte_pos POS_LEN_LO  = t_byte_pos'(2);
    localparam t_byte_pos POS_LEN_HI  = t_byte_pos'(3);
    localparam t_byte_pos POS_ZOOM_LO = t_byte_pos'(4);
    localparam t_byte_pos POS_ZOOM_HI = t_byte_pos'(5);
    localparam t_byte_pos POS_FOC_LO  = t_byte_pos'(6);
    localparam t_byte_pos POS_FOC_HI  = t_byte_pos'(7);

    localparam int        FRAME_OVERHEAD = 5;
    localparam t_byte_pos LAST_OFFSET    = t_byte_pos'(FRAME_OVERHEAD - 1);

    localparam logic [7:0] POS_ID_A = 8'h29;
    localparam logic [7:0] POS_ID_B = 8'h0D;

endpackage
`default_nettype wire

// File: sv/lens_response_deframer_unit.sv
// Lens response deframer: frames serial bytes into lens response results.
// Depends on lrd_pkg for frame layout constants and types.
//
// Usage:
//   The rx channel (i_rx_valid / o_rx_ready / i_rx_byte) carries one received
//   serial byte per request. A frame is a sync byte, a command id, a 16-bit
//   little-endian payload length, the payload and one checksum byte, for
//   length + 5 bytes in all. Sync and checksum values are not checked.
//   On the checksum byte one result request goes out on the resp channel
//   (o_resp_valid / i_resp_ready): id, length, checksum as received, and for
//   ids 0x29 and 0x0D with at least four payload bytes the zoom and focus
//   positions from payload bytes 0..3 with o_position_valid set; otherwise
//   both positions read zero. All other bytes produce no result.
//   The result is registered and visible in the cycle after its checksum byte
//   is accepted. One byte per cycle is taken while the output is not stalled;
//   the frame position updates between the byte input and the result register.
//   Stall: while a result waits in the output register and i_resp_ready is
//   low, o_rx_ready drops and no byte is taken; once the result leaves, or
//   in the same cycle it leaves, the next byte is accepted.
//   Reset (i_rst_n low, synchronous): the frame position returns to the sync
//   byte, captured header and positions clear and the output empties.
`default_nettype none
module lens_response_deframer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_resp_valid,
    input  wire logic        i_resp_ready,
    output logic [7:0]       o_response_id,
    output logic [15:0]      o_payload_length,
    output logic [15:0]      o_zoom_position,
    output logic [15:0]      o_focus_position,
    output logic             o_position_valid,
    output logic [7:0]       o_frame_checksum
);

    // Frame state
    lrd_pkg::t_byte_pos r_byte_pos,  n_byte_pos;
    logic [15:0]        r_frame_len, n_frame_len;
    logic [7:0]         r_frame_id,  n_frame_id;
    logic [15:0]        r_zoom,      n_zoom;
    logic [15:0]        r_focus,     n_focus;

    // Result register
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_id;
    logic [15:0]        r_out_len;
    logic [15:0]        r_out_zoom;
    logic [15:0]        r_out_focus;
    logic               r_out_pos_valid;
    logic [7:0]         r_out_cksum;

    logic               w_rx_acc;
    logic               w_last;
    logic               w_pos_valid;
    lrd_pkg::t_byte_pos w_last_pos;

    // Accept a byte whenever the result register is empty or draining now
    assign o_rx_ready = !r_out_valid || i_resp_ready;
    assign w_rx_acc   = i_rx_valid && o_rx_ready;

    // Checksum sits at length + 4; during the header this is always ahead
    assign w_last_pos = lrd_pkg::t_byte_pos'(r_frame_len) + lrd_pkg::LAST_OFFSET;
    assign w_last     = (r_byte_pos == w_last_pos);

    assign w_pos_valid = ((r_frame_id == lrd_pkg::POS_ID_A) ||
                          (r_frame_id == lrd_pkg::POS_ID_B)) &&
                         (|r_frame_len[15:2]);

    always_comb begin
        n_byte_pos  = r_byte_pos;
        n_frame_len = r_frame_len;
        n_frame_id  = r_frame_id;
        n_zoom      = r_zoom;
        n_focus     = r_focus;
        n_out_valid = r_out_valid && !i_resp_ready;
        if (w_rx_acc) begin
            if (w_last) begin
                // Complete the frame: emit and drop back to sync
                n_out_valid = 1'b1;
                n_byte_pos  = lrd_pkg::POS_SYNC;
                n_frame_len = '0;
                n_frame_id  = '0;
                n_zoom      = '0;
                n_focus     = '0;
            end else begin
                n_byte_pos = r_byte_pos + lrd_pkg::t_byte_pos'(1);
                case (r_byte_pos)
                    lrd_pkg::POS_ID:      n_frame_id         = i_rx_byte;
                    lrd_pkg::POS_LEN_LO:  n_frame_len        = {8'h00, i_rx_byte};
                    lrd_pkg::POS_LEN_HI:  n_frame_len[15:8]  = i_rx_byte;
                    lrd_pkg::POS_ZOOM_LO: n_zoom[7:0]        = i_rx_byte;
                    lrd_pkg::POS_ZOOM_HI: n_zoom[15:8]       = i_rx_byte;
                    lrd_pkg::POS_FOC_LO:  n_focus[7:0]       = i_rx_byte;
                    lrd_pkg::POS_FOC_HI:  n_focus[15:8]      = i_rx_byte;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= lrd_pkg::POS_SYNC;
            r_frame_len <= '0;
            r_frame_id  <= '0;
            r_zoom      <= '0;
            r_focus     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_byte_pos  <= n_byte_pos;
            r_frame_len <= n_frame_len;
            r_frame_id  <= n_frame_id;
            r_zoom      <= n_zoom;
            r_focus     <= n_focus;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload: load on the checksum byte, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_rx_acc && w_last) begin
            r_out_id        <= r_frame_id;
            r_out_len       <= r_frame_len;
            r_out_zoom      <= w_pos_valid ? r_zoom  : 16'h0000;
            r_out_focus     <= w_pos_valid ? r_focus : 16'h0000;
            r_out_pos_valid <= w_pos_valid;
            r_out_cksum     <= i_rx_byte;
        end
    end

    assign o_resp_valid     = r_out_valid;
    assign o_response_id    = r_out_id;
    assign o_payload_length = r_out_len;
    assign o_zoom_position  = r_out_zoom;
    assign o_focus_position = r_out_focus;
    assign o_position_valid = r_out_pos_valid;
    assign o_frame_checksum = r_out_cksum;

    // Completing a frame returns the parser to the sync byte
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rx_acc && w_last) |=> (r_byte_pos == lrd_pkg::POS_SYNC))
        else $error("deframer did not return to sync after checksum byte");

    // Position never runs past the checksum slot of the current frame
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_pos <= lrd_pkg::POS_LEN_HI) || (r_byte_pos <= w_last_pos))
        else $error("byte position beyond end of frame");

    // A flagged position result carries a position id and a long enough payload
    a_pos_valid_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_valid && o_position_valid) |->
            (((o_response_id == lrd_pkg::POS_ID_A) ||
              (o_response_id == lrd_pkg::POS_ID_B)) && (|o_payload_length[15:2])))
        else $error("position flagged for non-position frame");

    // Unflagged results carry zero positions
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_valid && !o_position_valid) |->
            ((o_zoom_position == 16'h0000) && (o_focus_position == 16'h0000)))
        else $error("nonzero position without valid flag");

endmodule
`default_nettype wire

// File: sim/lrd_response_checker.sv
`timescale 1ns / 1ps
// Response checker for lens_response_deframer_unit: tracks frame position per accepted byte,
// queues expected frame results and compares them against the resp channel.
// Depends on lrd_pkg for the frame layout constants and the position type.
module lrd_response_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_resp_valid,
    input  logic        i_resp_ready,
    input  logic [7:0]  i_response_id,
    input  logic [15:0] i_payload_length,
    input  logic [15:0] i_zoom_position,
    input  logic [15:0] i_focus_position,
    input  logic        i_position_valid,
    input  logic [7:0]  i_frame_checksum,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0]  resp_id;
        logic [15:0] pay_len;
        logic [15:0] zoom;
        logic [15:0] focus;
        logic        pos_ok;
        logic [7:0]  checksum;
    } t_lens_result;

    // Frame tracking state
    lrd_pkg::t_byte_pos frame_pos;
    logic [15:0]        hdr_length;
    logic [7:0]         hdr_id;
    logic [15:0]        zoom_cap;
    logic [15:0]        focus_cap;

    t_lens_result frame_results_q[$];
    int           fail_total = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic clear_frame();
        frame_pos  = lrd_pkg::POS_SYNC;
        hdr_length = '0;
        hdr_id     = '0;
        zoom_cap   = '0;
        focus_cap  = '0;
    endtask

    // Advance the frame by one byte; queue a result on the checksum byte.
    task automatic take_byte(input logic [7:0] b);
        lrd_pkg::t_byte_pos last_pos;
        t_lens_result       r;
        logic               done;
        done     = 1'b0;
        last_pos = lrd_pkg::t_byte_pos'({1'b0, hdr_length}) + lrd_pkg::LAST_OFFSET;
        if (frame_pos == lrd_pkg::POS_ID) begin
            hdr_id = b;
        end else if (frame_pos == lrd_pkg::POS_LEN_LO) begin
            hdr_length = {8'h00, b};
        end else if (frame_pos == lrd_pkg::POS_LEN_HI) begin
            hdr_length = {b, hdr_length[7:0]};
        end else if (frame_pos >= lrd_pkg::POS_ZOOM_LO) begin
            if (frame_pos == last_pos) begin
                r.resp_id  = hdr_id;
                r.pay_len  = hdr_length;
                r.pos_ok   = (hdr_id == lrd_pkg::POS_ID_A || hdr_id == lrd_pkg::POS_ID_B) &&
                             hdr_length >= 16'd4;
                r.zoom     = r.pos_ok ? zoom_cap : 16'h0000;
                r.focus    = r.pos_ok ? focus_cap : 16'h0000;
                r.checksum = b;
                frame_results_q.push_back(r);
                clear_frame();
                done = 1'b1;
            end else if (frame_pos == lrd_pkg::POS_ZOOM_LO) begin
                zoom_cap[7:0] = b;
            end else if (frame_pos == lrd_pkg::POS_ZOOM_HI) begin
                zoom_cap[15:8] = b;
            end else if (frame_pos == lrd_pkg::POS_FOC_LO) begin
                focus_cap[7:0] = b;
            end else if (frame_pos == lrd_pkg::POS_FOC_HI) begin
                focus_cap[15:8] = b;
            end
        end
        if (!done) frame_pos = frame_pos + lrd_pkg::t_byte_pos'(1);
    endtask

    always @(posedge i_clk) begin : watch
        t_lens_result got;
        t_lens_result want;
        if (!i_rst_n) begin
            clear_frame();
            frame_results_q.delete();
        end else begin
            // Retire the oldest result first: a checksum byte taken in the
            // same cycle belongs to a later frame.
            if (i_resp_valid && i_resp_ready) begin
                got.resp_id  = i_response_id;
                got.pay_len  = i_payload_length;
                got.zoom     = i_zoom_position;
                got.focus    = i_focus_position;
                got.pos_ok   = i_position_valid;
                got.checksum = i_frame_checksum;
                if (frame_results_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%0t: unexpected result id %h len %h", $realtime,
                                 got.resp_id, got.pay_len);
                end else begin
                    want = frame_results_q.pop_front();
                    if (got.resp_id !== want.resp_id || got.pay_len !== want.pay_len ||
                        got.zoom !== want.zoom || got.focus !== want.focus ||
                        got.pos_ok !== want.pos_ok || got.checksum !== want.checksum) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display({"%0t: result differs (exp/got) id %h/%h len %h/%h",
                                      " zoom %h/%h focus %h/%h valid %b/%b sum %h/%h"},
                                     $realtime, want.resp_id, got.resp_id,
                                     want.pay_len, got.pay_len, want.zoom, got.zoom,
                                     want.focus, got.focus, want.pos_ok, got.pos_ok,
                                     want.checksum, got.checksum);
                    end
                end
            end
            if (i_rx_valid && i_rx_ready) take_byte(i_rx_byte);
        end
        o_pending    <= frame_results_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the lens_response_deframer_unit testbench: clock, reset, byte stimulus,
// resp backpressure and the verdict. Depends on lrd_pkg and lrd_response_checker.
module tb_top;

    localparam int HOLD_CYCLES    = 400;    // long resp hold-off to fill the block
    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no request moving
    localparam int PHASE_BYTES    = 210;
    localparam int TAIL_CYCLES    = 10;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    logic        i_clk = 1'b0;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_ready;
    logic [7:0]  rx_byte;
    logic        resp_valid;
    logic        resp_ready = 1'b0;
    logic [7:0]  response_id;
    logic [15:0] payload_length;
    logic [15:0] zoom_position;
    logic [15:0] focus_position;
    logic        position_valid;
    logic [7:0]  frame_checksum;

    int results_pending;
    int fail_count;

    // Idling knobs, percent of cycles; written only by the stimulus process.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_token     = 0;   // bump to request one long resp hold-off

    int hold_seen  = 0;
    int hold_left  = 0;
    int sent_bytes = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    lens_response_deframer_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_rx_valid       (rx_valid),
        .o_rx_ready       (rx_ready),
        .i_rx_byte        (rx_byte),
        .o_resp_valid     (resp_valid),
        .i_resp_ready     (resp_ready),
        .o_response_id    (response_id),
        .o_payload_length (payload_length),
        .o_zoom_position  (zoom_position),
        .o_focus_position (focus_position),
        .o_position_valid (position_valid),
        .o_frame_checksum (frame_checksum)
    );

    lrd_response_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_rx_valid       (rx_valid),
        .i_rx_ready       (rx_ready),
        .i_rx_byte        (rx_byte),
        .i_resp_valid     (resp_valid),
        .i_resp_ready     (resp_ready),
        .i_response_id    (response_id),
        .i_payload_length (payload_length),
        .i_zoom_position  (zoom_position),
        .i_focus_position (focus_position),
        .i_position_valid (position_valid),
        .i_frame_checksum (frame_checksum),
        .o_pending        (results_pending),
        .o_fail_count     (fail_count)
    );

    // Resp side: stall at random, or hold ready low for a long stretch when
    // the stimulus asks for it. The stretch is counted here, not by the sender.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            resp_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_token != hold_seen) begin
            hold_seen  <= hold_token;
            hold_left  <= HOLD_CYCLES - 1;
            resp_ready <= 1'b0;
        end else begin
            resp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no request moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!rst_n || (rx_valid && rx_ready) || (resp_valid && resp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one byte request, idling first if the sender is set to idle.
    // Returns on the falling edge after acceptance; the caller either offers
    // the next byte or drops valid in that same step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_valid = 1'b0;
            @(negedge i_clk);
        end
        rx_valid = 1'b1;
        rx_byte  = b;
        @(posedge i_clk);
        while (!rx_ready) @(posedge i_clk);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] fill_byte(input t_fill fill);
        case (fill)
            FILL_ZERO: fill_byte = 8'h00;
            FILL_ONES: fill_byte = 8'hFF;
            default:   fill_byte = 8'($urandom_range(255));
        endcase
    endfunction

    // One full frame: sync, id, length (little endian), payload, checksum.
    // Sync, payload and checksum take the fill pattern.
    task automatic send_frame(input logic [7:0] id, input logic [15:0] len, input t_fill fill);
        send_byte(fill_byte(fill));
        send_byte(id);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int i = 0; i < int'(len); i++) send_byte(fill_byte(fill));
        send_byte(fill_byte(fill));
    endtask

    // Drop valid and hold the sender until every queued result has left.
    task automatic wait_drained();
        rx_valid = 1'b0;
        while (results_pending != 0) @(negedge i_clk);
    endtask

    // Random frames until roughly byte_budget bytes have gone in. Lengths are
    // mostly short so that results come often; position ids are favored.
    task automatic send_random_frames(input int byte_budget);
        int          stop_at;
        int          pick;
        logic [7:0]  id;
        logic [15:0] len;
        stop_at = sent_bytes + byte_budget;
        while (sent_bytes < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45)
                id = $urandom_range(1) ? lrd_pkg::POS_ID_A : lrd_pkg::POS_ID_B;
            else
                id = 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 70)
                len = 16'($urandom_range(8));
            else if (pick < 95)
                len = 16'($urandom_range(40, 9));
            else
                len = 16'($urandom_range(300, 41));
            send_frame(id, len, FILL_RANDOM);
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        rx_valid = 1'b0;
        rx_byte  = 8'h00;
        repeat (10) @(negedge i_clk);
        rst_n = 1'b1;

        // Directed: position frame with all-ones bytes, short payload on a
        // position id, empty payload (checksum right after the header), and
        // a non-position id with a one-byte payload.
        send_frame(lrd_pkg::POS_ID_A, 16'd4, FILL_ONES);
        send_frame(lrd_pkg::POS_ID_B, 16'd3, FILL_ZERO);
        send_frame(8'h00, 16'd0, FILL_RANDOM);
        send_frame(8'hFF, 16'd1, FILL_ONES);
        wait_drained();

        // Unthrottled pass, plus a frame whose length uses the high byte
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_frames(PHASE_BYTES);
        send_frame(lrd_pkg::POS_ID_B, 16'h0100, FILL_RANDOM);
        wait_drained();

        // Sender idles often
        send_idle_pct  = 68;
        recv_stall_pct = 0;
        send_random_frames(PHASE_BYTES);
        wait_drained();

        // Receiver stalls often
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        send_random_frames(PHASE_BYTES);
        wait_drained();

        // Both sides throttled
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        send_random_frames(PHASE_BYTES);
        wait_drained();

        // Back-pressure: hold resp ready low while short frames keep coming,
        // so a result sits in the output and the block stops taking bytes.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_token     = hold_token + 1;
        for (int i = 0; i < 30; i++)
            send_frame($urandom_range(1) ? lrd_pkg::POS_ID_A : 8'($urandom_range(255)),
                       16'($urandom_range(4)), FILL_RANDOM);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
sv/lrd_pkg.sv
sv/lens_response_deframer_unit.sv
sim/lrd_response_checker.sv
sim/tb_top.sv
